[rtl/core/gdpc_pkg.sv]
// shared constants, command and status types for the pose controller
package gdpc_pkg;

    localparam int ITERATIONS_DEF = 100;
    localparam int WORD_BITS_DEF  = 32;

    localparam int VEL_W   = 18;
    localparam int OMEGA_W = 17;
    localparam int STEP_W  = 17;
    localparam int CWGT_W  = 20;
    localparam int THR_W   = 20;
    localparam int CFG_W   = 20;
    localparam int CFG_AW  = 2;
    localparam int ZW      = 20;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 152;

    localparam logic [CFG_AW-1:0] REG_STEP_TIME   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_CTRL_WEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_REACH_THR   = 2'd2;

    localparam logic [STEP_W-1:0] STEP_RST = 17'd3277;
    localparam logic [CWGT_W-1:0] CWGT_RST = 20'd6554;
    localparam logic [THR_W-1:0]  THR_RST  = 20'd19661;

    localparam logic OPC_SET  = 1'b0;
    localparam logic OPC_TICK = 1'b1;

    localparam logic signed [VEL_W-1:0] CTRL_INIT  = 18'sd3277;
    localparam logic signed [VEL_W-1:0] CTRL_DELTA = 18'sd655;
    localparam logic signed [VEL_W-1:0] VEL_LIM    = 18'sd65536;
    localparam logic signed [VEL_W-1:0] OMEGA_LIM  = 18'sd51472;
    localparam logic signed [ZW-1:0]    HALF_PI    = 20'sd102944;
    localparam logic [30:0]             AXIS_LIM   = 31'h7FFF_FFFF;

    // micro-operations of one cost evaluation, issued in this order
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_MX    = 4'd1;
    localparam logic [3:0] OP_MY    = 4'd2;
    localparam logic [3:0] OP_MH    = 4'd3;
    localparam logic [3:0] OP_SQX   = 4'd4;
    localparam logic [3:0] OP_SQY   = 4'd5;
    localparam logic [3:0] OP_SQW   = 4'd6;
    localparam logic [3:0] OP_DX2   = 4'd7;
    localparam logic [3:0] OP_DY2   = 4'd8;
    localparam logic [3:0] OP_WGT   = 4'd9;
    localparam logic [3:0] OP_START = 4'd10;

    localparam logic [1:0] PERT_NONE = 2'd0;
    localparam logic [1:0] PERT_VX   = 2'd1;
    localparam logic [1:0] PERT_VY   = 2'd2;
    localparam logic [1:0] PERT_W    = 2'd3;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] sel;
        logic       load_target;
        logic       init_ctrl;
        logic       eval_cost;
        logic       grad;
        logic       commit_ctrl;
        logic       commit_pose;
    } gdpc_cmd_t;

    typedef struct packed {
        logic armed;
        logic busy;
        logic out_full;
    } gdpc_sts_t;

    function automatic logic [16:0] atan_entry(input logic [3:0] i);
        logic [16:0] v;
        case (i)
            4'd0:    v = 17'd51472;
            4'd1:    v = 17'd30386;
            4'd2:    v = 17'd16055;
            4'd3:    v = 17'd8150;
            4'd4:    v = 17'd4091;
            4'd5:    v = 17'd2047;
            4'd6:    v = 17'd1024;
            4'd7:    v = 17'd512;
            4'd8:    v = 17'd256;
            4'd9:    v = 17'd128;
            4'd10:   v = 17'd64;
            4'd11:   v = 17'd32;
            4'd12:   v = 17'd16;
            4'd13:   v = 17'd8;
            4'd14:   v = 17'd4;
            4'd15:   v = 17'd2;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/gdpc_ctrl.sv]
// sequencer for the gradient-descent iterations and cost evaluations
module gdpc_ctrl #(
    parameter int ITERATIONS = gdpc_pkg::ITERATIONS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_opcode,
    output logic                in_ready,
    output gdpc_pkg::gdpc_cmd_t cmd,
    input  gdpc_pkg::gdpc_sts_t sts
);

    localparam int IW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;
    localparam logic [2:0] S_OPS    = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_COST   = 3'd4;
    localparam logic [2:0] S_GRAD   = 3'd5;
    localparam logic [2:0] S_COMMIT = 3'd6;
    localparam logic [2:0] S_POSE   = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [3:0]    op_reg, op_next;
    logic [1:0]    sel_reg, sel_next;
    logic [IW-1:0] iter_reg, iter_next;
    logic          final_reg, final_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= gdpc_pkg::OP_NONE;
            sel_reg   <= gdpc_pkg::PERT_NONE;
            iter_reg  <= '0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            sel_reg   <= sel_next;
            iter_reg  <= iter_next;
            final_reg <= final_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        sel_next   = sel_reg;
        iter_next  = iter_reg;
        final_next = final_reg;
        cmd        = '0;
        cmd.op     = gdpc_pkg::OP_NONE;
        cmd.sel    = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_opcode == gdpc_pkg::OPC_SET)
                        cmd.load_target = 1'b1;
                    else if (sts.armed)
                        state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init_ctrl = 1'b1;
                sel_next      = gdpc_pkg::PERT_NONE;
                iter_next     = '0;
                final_next    = 1'b0;
                op_next       = gdpc_pkg::OP_MX;
                state_next    = S_OPS;
            end
            S_OPS:
            begin
                cmd.op = op_reg;
                if (op_reg == gdpc_pkg::OP_START)
                    state_next = S_WAIT;
                else
                    op_next = op_reg + 4'd1;
            end
            S_WAIT:
            begin
                if (!sts.busy)
                    state_next = final_reg ? S_POSE : S_COST;
            end
            S_COST:
            begin
                cmd.eval_cost = 1'b1;
                if (sel_reg == gdpc_pkg::PERT_NONE)
                begin
                    sel_next   = gdpc_pkg::PERT_VX;
                    op_next    = gdpc_pkg::OP_MX;
                    state_next = S_OPS;
                end
                else
                    state_next = S_GRAD;
            end
            S_GRAD:
            begin
                cmd.grad = 1'b1;
                if (sel_reg == gdpc_pkg::PERT_W)
                    state_next = S_COMMIT;
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    op_next    = gdpc_pkg::OP_MX;
                    state_next = S_OPS;
                end
            end
            S_COMMIT:
            begin
                cmd.commit_ctrl = 1'b1;
                sel_next        = gdpc_pkg::PERT_NONE;
                op_next         = gdpc_pkg::OP_MX;
                state_next      = S_OPS;
                // last pass evaluates the final controls to advance the pose
                if (iter_reg == IW'(ITERATIONS - 1))
                    final_next = 1'b1;
                else
                    iter_next = iter_reg + IW'(1);
            end
            S_POSE:
            begin
                if (!sts.out_full)
                begin
                    cmd.commit_pose = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_ops_units_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OPS) |-> !sts.busy)
        else $error("micro-operations issued while a unit is still running");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        iter_reg <= IW'(ITERATIONS - 1))
        else $error("iteration counter past its last value");

    a_commit_after_omega: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> ($past(state_reg) == S_GRAD && sel_reg == gdpc_pkg::PERT_W))
        else $error("controls committed before all three gradients were taken");

endmodule

[rtl/core/gdpc_dp.sv]
// datapath: pose state, shared multiplier, square root and cordic units, output register
module gdpc_dp #(
    parameter int WORD_BITS = gdpc_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gdpc_pkg::gdpc_cmd_t           cmd,
    output gdpc_pkg::gdpc_sts_t           sts,
    input  logic                          cfg_we,
    input  logic [gdpc_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [gdpc_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic signed [31:0]            goal_x,
    input  logic signed [31:0]            goal_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gdpc_pkg::OUT_W-1:0]    out_data
);

    localparam int W   = WORD_BITS;
    localparam int W1  = W + 1;
    localparam int CDW = W + 3;
    localparam int DXW = (W + 1 > 33) ? W + 1 : 33;
    localparam int GW  = ((W > 32) ? W : 32) + 1;
    localparam int OW  = (W > 32) ? W : 32;
    localparam int CW  = ((W + 2 > 33) ? W + 2 : 33) + 2;
    localparam int DW  = CW + 9;
    localparam int MW  = 33;
    localparam int VW  = gdpc_pkg::VEL_W;
    localparam int OMW = gdpc_pkg::OMEGA_W;
    localparam int ZW  = gdpc_pkg::ZW;

    localparam logic signed [GW-1:0] WMAX = {{(GW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [GW-1:0] WMIN = ~WMAX;

    // control and state registers
    logic signed [W-1:0]              pose_x_reg, pose_y_reg, head_reg;
    logic signed [W-1:0]              tgt_x_reg, tgt_y_reg;
    logic                             armed_reg;
    logic [gdpc_pkg::STEP_W-1:0]      step_reg;
    logic [gdpc_pkg::CWGT_W-1:0]      cw_reg;
    logic [gdpc_pkg::THR_W-1:0]       thr_reg;
    logic [3:0]                       op_d_reg;
    logic                             sq_busy_reg, cd_busy_reg, out_valid_reg;

    // payload registers
    logic signed [VW-1:0]             vx_reg, vy_reg, nvx_reg, nvy_reg;
    logic signed [OMW-1:0]            w_reg, nw_reg;
    logic signed [W-1:0]              px_reg, py_reg, ph_reg;
    logic signed [2*MW-1:0]           prod_reg;
    logic [33:0]                      eff_reg;
    logic [62:0]                      sq_reg;
    logic [21:0]                      wgt_reg;
    logic [CW-1:0]                    cost_reg, c0_reg;
    logic [63:0]                      rem_reg, res_reg, bit_reg;
    logic signed [CDW-1:0]            cx_reg, cy_reg;
    logic signed [ZW-1:0]             cz_reg;
    logic [3:0]                       cd_cnt_reg;
    logic [149:0]                     out_data_reg;

    // candidate controls with the selected perturbation
    logic signed [VW-1:0]  cu_x, cu_y;
    logic signed [OMW-1:0] cu_w;
    logic signed [MW-1:0]  ma, mb;
    logic signed [W-1:0]   adv_base, adv_sat;
    logic signed [2*MW-1:0] adv_sh;
    logic signed [W:0]     adv_sum;
    logic signed [W:0]     dx, dy;
    logic signed [DXW-1:0] dxe, dye;
    logic [DXW-1:0]        magx, magy;
    logic [30:0]           adx, ady;
    logic signed [CDW-1:0] xs, ys;
    logic [63:0]           sq_try;
    logic [32:0]           dist_val;
    logic signed [W:0]     dev;
    logic [W:0]            adev;
    logic [CW-1:0]         cost_c;
    logic signed [DW-1:0]  diff, grad_g, vsel, nv, lim, ncl;
    logic signed [GW-1:0]  gx_e, gy_e;
    logic signed [W-1:0]   gx_s, gy_s;
    logic                  reached;
    logic signed [OW-1:0]  opx, opy, oph;

    assign cu_x = vx_reg + ((cmd.sel == gdpc_pkg::PERT_VX) ? gdpc_pkg::CTRL_DELTA : VW'(0));
    assign cu_y = vy_reg + ((cmd.sel == gdpc_pkg::PERT_VY) ? gdpc_pkg::CTRL_DELTA : VW'(0));
    assign cu_w = w_reg + ((cmd.sel == gdpc_pkg::PERT_W) ? OMW'(gdpc_pkg::CTRL_DELTA)
                                                         : OMW'(0));

    // target minus predicted position
    assign dx = W1'(tgt_x_reg) - W1'(px_reg);
    assign dy = W1'(tgt_y_reg) - W1'(py_reg);
    assign dxe  = DXW'(dx);
    assign dye  = DXW'(dy);
    assign magx = dxe[DXW-1] ? -dxe : dxe;
    assign magy = dye[DXW-1] ? -dye : dye;
    assign adx  = (magx > DXW'(gdpc_pkg::AXIS_LIM)) ? gdpc_pkg::AXIS_LIM : magx[30:0];
    assign ady  = (magy > DXW'(gdpc_pkg::AXIS_LIM)) ? gdpc_pkg::AXIS_LIM : magy[30:0];

    // shared multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            gdpc_pkg::OP_MX:
            begin
                ma = MW'(cu_x);
                mb = MW'(step_reg);
            end
            gdpc_pkg::OP_MY:
            begin
                ma = MW'(cu_y);
                mb = MW'(step_reg);
            end
            gdpc_pkg::OP_MH:
            begin
                ma = MW'(cu_w);
                mb = MW'(step_reg);
            end
            gdpc_pkg::OP_SQX:
            begin
                ma = MW'(cu_x);
                mb = MW'(cu_x);
            end
            gdpc_pkg::OP_SQY:
            begin
                ma = MW'(cu_y);
                mb = MW'(cu_y);
            end
            gdpc_pkg::OP_SQW:
            begin
                ma = MW'(cu_w);
                mb = MW'(cu_w);
            end
            gdpc_pkg::OP_DX2:
            begin
                ma = MW'(adx);
                mb = MW'(adx);
            end
            gdpc_pkg::OP_DY2:
            begin
                ma = MW'(ady);
                mb = MW'(ady);
            end
            gdpc_pkg::OP_WGT:
            begin
                ma = MW'(eff_reg[33:16]);
                mb = MW'(cw_reg);
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // pose prediction from the registered product, saturated to the word
    always_comb
    begin
        case (op_d_reg)
            gdpc_pkg::OP_MY: adv_base = pose_y_reg;
            gdpc_pkg::OP_MH: adv_base = head_reg;
            default:         adv_base = pose_x_reg;
        endcase
        adv_sh  = prod_reg >>> 16;
        adv_sum = W1'(adv_base) + W1'(adv_sh);
        if (adv_sum[W] != adv_sum[W-1])
            adv_sat = adv_sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            adv_sat = adv_sum[W-1:0];
    end

    assign xs       = CDW'(dx);
    assign ys       = CDW'(dy);
    assign sq_try   = res_reg + bit_reg;
    assign dist_val = res_reg[32:0];

    // cost of the current candidate
    assign dev    = W1'(cz_reg) - W1'(ph_reg);
    assign adev   = dev[W] ? -dev : dev;
    assign cost_c = CW'(dist_val) + CW'(wgt_reg) + (CW'(adev) << 1);

    // gradient step on the perturbed axis
    always_comb
    begin
        diff   = DW'(cost_reg) - DW'(c0_reg);
        grad_g = (diff <<< 6) + (diff <<< 5) + (diff <<< 2);
        case (cmd.sel)
            gdpc_pkg::PERT_VY: vsel = DW'(vy_reg);
            gdpc_pkg::PERT_W:  vsel = DW'(w_reg);
            default:           vsel = DW'(vx_reg);
        endcase
        lim = (cmd.sel == gdpc_pkg::PERT_W) ? DW'(gdpc_pkg::OMEGA_LIM)
                                            : DW'(gdpc_pkg::VEL_LIM);
        nv  = vsel - grad_g;
        if (nv > lim)
            ncl = lim;
        else if (nv < -lim)
            ncl = -lim;
        else
            ncl = nv;
    end

    // incoming target saturated to the word
    always_comb
    begin
        gx_e = GW'(goal_x);
        gy_e = GW'(goal_y);
        if (gx_e > WMAX)
            gx_s = WMAX[W-1:0];
        else if (gx_e < WMIN)
            gx_s = WMIN[W-1:0];
        else
            gx_s = gx_e[W-1:0];
        if (gy_e > WMAX)
            gy_s = WMAX[W-1:0];
        else if (gy_e < WMIN)
            gy_s = WMIN[W-1:0];
        else
            gy_s = gy_e[W-1:0];
    end

    assign reached = dist_val < 33'(thr_reg);
    assign opx = OW'(px_reg);
    assign opy = OW'(py_reg);
    assign oph = OW'(ph_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            head_reg      <= '0;
            tgt_x_reg     <= '0;
            tgt_y_reg     <= '0;
            armed_reg     <= 1'b0;
            step_reg      <= gdpc_pkg::STEP_RST;
            cw_reg        <= gdpc_pkg::CWGT_RST;
            thr_reg       <= gdpc_pkg::THR_RST;
            op_d_reg      <= gdpc_pkg::OP_NONE;
            sq_busy_reg   <= 1'b0;
            cd_busy_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            op_d_reg <= cmd.op;
            if (cfg_we)
            begin
                case (cfg_addr)
                    gdpc_pkg::REG_STEP_TIME:   step_reg <= cfg_wdata[gdpc_pkg::STEP_W-1:0];
                    gdpc_pkg::REG_CTRL_WEIGHT: cw_reg   <= cfg_wdata[gdpc_pkg::CWGT_W-1:0];
                    gdpc_pkg::REG_REACH_THR:   thr_reg  <= cfg_wdata[gdpc_pkg::THR_W-1:0];
                    default:                   ;
                endcase
            end
            if (cmd.load_target)
            begin
                tgt_x_reg <= gx_s;
                tgt_y_reg <= gy_s;
                armed_reg <= 1'b1;
            end
            if (cmd.op == gdpc_pkg::OP_START)
            begin
                sq_busy_reg <= 1'b1;
                cd_busy_reg <= 1'b1;
            end
            else
            begin
                if (sq_busy_reg && bit_reg[0])
                    sq_busy_reg <= 1'b0;
                if (cd_busy_reg && cd_cnt_reg == 4'd15)
                    cd_busy_reg <= 1'b0;
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.commit_pose)
            begin
                pose_x_reg    <= px_reg;
                pose_y_reg    <= py_reg;
                head_reg      <= ph_reg;
                out_valid_reg <= 1'b1;
                if (reached)
                    armed_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        case (op_d_reg)
            gdpc_pkg::OP_MX:  px_reg  <= adv_sat;
            gdpc_pkg::OP_MY:  py_reg  <= adv_sat;
            gdpc_pkg::OP_MH:  ph_reg  <= adv_sat;
            gdpc_pkg::OP_SQX: eff_reg <= prod_reg[33:0];
            gdpc_pkg::OP_SQY: eff_reg <= eff_reg + prod_reg[33:0];
            gdpc_pkg::OP_SQW: eff_reg <= eff_reg + prod_reg[33:0];
            gdpc_pkg::OP_DX2: sq_reg  <= prod_reg[62:0];
            gdpc_pkg::OP_DY2: sq_reg  <= sq_reg + prod_reg[62:0];
            gdpc_pkg::OP_WGT: wgt_reg <= prod_reg[37:16];
            default:          ;
        endcase

        // bit-serial integer square root, one result bit a cycle
        if (cmd.op == gdpc_pkg::OP_START)
        begin
            rem_reg <= {1'b0, sq_reg};
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (sq_busy_reg)
        begin
            if (rem_reg >= sq_try)
            begin
                rem_reg <= rem_reg - sq_try;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end

        // cordic vectoring with quadrant pre-rotation, frozen once y is zero
        if (cmd.op == gdpc_pkg::OP_START)
        begin
            cd_cnt_reg <= '0;
            if (xs < 0)
            begin
                if (ys >= 0)
                begin
                    cx_reg <= ys;
                    cy_reg <= -xs;
                    cz_reg <= gdpc_pkg::HALF_PI;
                end
                else
                begin
                    cx_reg <= -ys;
                    cy_reg <= xs;
                    cz_reg <= -gdpc_pkg::HALF_PI;
                end
            end
            else
            begin
                cx_reg <= xs;
                cy_reg <= ys;
                cz_reg <= '0;
            end
        end
        else if (cd_busy_reg)
        begin
            cd_cnt_reg <= cd_cnt_reg + 4'd1;
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + (cy_reg >>> cd_cnt_reg);
                cy_reg <= cy_reg - (cx_reg >>> cd_cnt_reg);
                cz_reg <= cz_reg + $signed({3'b000, gdpc_pkg::atan_entry(cd_cnt_reg)});
            end
            else if (cy_reg < 0)
            begin
                cx_reg <= cx_reg - (cy_reg >>> cd_cnt_reg);
                cy_reg <= cy_reg + (cx_reg >>> cd_cnt_reg);
                cz_reg <= cz_reg - $signed({3'b000, gdpc_pkg::atan_entry(cd_cnt_reg)});
            end
        end

        if (cmd.eval_cost)
        begin
            cost_reg <= cost_c;
            if (cmd.sel == gdpc_pkg::PERT_NONE)
                c0_reg <= cost_c;
        end
        if (cmd.grad)
        begin
            case (cmd.sel)
                gdpc_pkg::PERT_VY: nvy_reg <= VW'(ncl);
                gdpc_pkg::PERT_W:  nw_reg  <= OMW'(ncl);
                default:           nvx_reg <= VW'(ncl);
            endcase
        end
        if (cmd.init_ctrl)
        begin
            vx_reg <= gdpc_pkg::CTRL_INIT;
            vy_reg <= gdpc_pkg::CTRL_INIT;
            w_reg  <= OMW'(gdpc_pkg::CTRL_INIT);
        end
        else if (cmd.commit_ctrl)
        begin
            vx_reg <= nvx_reg;
            vy_reg <= nvy_reg;
            w_reg  <= nw_reg;
        end
        if (cmd.commit_pose)
            out_data_reg <= {reached, oph[31:0], opy[31:0], opx[31:0], w_reg, vy_reg, vx_reg};
    end

    assign sts.armed    = armed_reg;
    assign sts.busy     = sq_busy_reg | cd_busy_reg;
    assign sts.out_full = out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_data     = {2'b00, out_data_reg};

    a_units_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == gdpc_pkg::OP_START) |=> (sq_busy_reg && cd_busy_reg))
        else $error("square root and cordic did not start together");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_pose |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before its beat was taken");

    a_ctrl_limits: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.commit_ctrl) |->
            (vx_reg <= gdpc_pkg::VEL_LIM && vx_reg >= -gdpc_pkg::VEL_LIM &&
             vy_reg <= gdpc_pkg::VEL_LIM && vy_reg >= -gdpc_pkg::VEL_LIM))
        else $error("committed velocity outside its clamp");

endmodule

[rtl/core/gradient_descent_pose_controller.sv]
// top level: gradient-descent pose controller with stream ports and config writes
// set-target beat: taken while idle, no result; tick without target: taken while idle, no result
// armed tick: run time set by the bit-serial square root
//   that runs for each of the four cost evaluations per iteration
// one item at a time; a finished result waits in the output register while a new beat is taken
// reset (rst_n low, asynchronous): pose and target cleared, target disarmed, registers to defaults
module gradient_descent_pose_controller #(
    parameter int ITERATIONS = gdpc_pkg::ITERATIONS_DEF,
    parameter int WORD_BITS  = gdpc_pkg::WORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [gdpc_pkg::IN_W-1:0]          s_axis_tdata,  // goal_x, goal_y
    input  logic [0:0]                         s_axis_tuser,  // opcode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // cmd_vx, cmd_vy, cmd_omega, pose_x_out, pose_y_out, heading_out, reached
    output logic [gdpc_pkg::OUT_W-1:0]         m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [gdpc_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [gdpc_pkg::CFG_W-1:0]         cfg_wdata
);

    gdpc_pkg::gdpc_cmd_t cmd;
    gdpc_pkg::gdpc_sts_t sts;

    gdpc_ctrl #(
        .ITERATIONS (ITERATIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (s_axis_tuser[0]),
        .in_ready  (s_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    gdpc_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .goal_x    (s_axis_tdata[31:0]),
        .goal_y    (s_axis_tdata[63:32]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

[verif/gradient_descent_pose_controller_tb.sv]
// testbench for the gradient-descent pose controller: scoreboard against an in-bench predictor
module gradient_descent_pose_controller_tb;

    localparam longint CYCLE_LIMIT = 8000000;
    localparam longint WORD_MAX    = 64'sd2147483647;
    localparam longint WORD_MIN    = -64'sd2147483648;
    localparam longint ATAN_TAB [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2};

    typedef struct {
        logic        opc;
        logic [31:0] gx;
        logic [31:0] gy;
    } pose_cmd_t;

    typedef struct {
        logic [17:0] vx;
        logic [17:0] vy;
        logic [16:0] w;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] hd;
        logic        reached;
    } ctrl_out_t;

    logic                        clk;
    logic                        rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [gdpc_pkg::IN_W-1:0]   s_axis_tdata;
    logic [0:0]                  s_axis_tuser;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [gdpc_pkg::OUT_W-1:0]  m_axis_tdata;
    logic                        cfg_we;
    logic [gdpc_pkg::CFG_AW-1:0] cfg_addr;
    logic [gdpc_pkg::CFG_W-1:0]  cfg_wdata;

    pose_cmd_t cmd_q[$];
    ctrl_out_t ctrl_q[$];
    logic      took;
    logic      out_took;
    int        in_gap;
    int        out_gap;
    bit        no_idle;
    int        errors;
    longint    cycles;

    // predictor state
    longint pose_x, pose_y, heading, tgt_x, tgt_y;
    bit     armed;
    longint dt, cweight, thresh;

    gradient_descent_pose_controller DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_to(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > n) bits = bits >> 2;
        while (bits != 0)
        begin
            if (n >= res + bits)
            begin
                n = n - (res + bits);
                res = (res >> 1) + bits;
            end
            else
                res = res >> 1;
            bits = bits >> 2;
        end
        return res;
    endfunction

    function automatic longint dist_from(longint px, longint py);
        longint dx, dy;
        longint unsigned ux, uy;
        dx = clamp_to(tgt_x - px, WORD_MAX);
        dy = clamp_to(tgt_y - py, WORD_MAX);
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        return longint'(int_sqrt(ux * ux + uy * uy));
    endfunction

    // cordic vectoring, stops once the residual is zero
    function automatic longint bearing_of(longint y, longint x);
        longint z, t, nx, ny;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = 102944;
            end
            else
            begin
                t = x; x = -y; y = t; z = -102944;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            if (y == 0) break;
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + ATAN_TAB[i];
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic longint integrate(longint p, longint u);
        return sat_word(p + ((u * dt) >>> 16));
    endfunction

    function automatic longint plan_cost(longint vx, longint vy, longint w);
        longint px, py, ph, effort, dev;
        px = integrate(pose_x, vx);
        py = integrate(pose_y, vy);
        ph = integrate(heading, w);
        effort = (vx * vx + vy * vy + w * w) >>> 16;
        dev = bearing_of(tgt_y - py, tgt_x - px) - ph;
        if (dev < 0) dev = -dev;
        return dist_from(px, py) + ((cweight * effort) >>> 16) + 2 * dev;
    endfunction

    task automatic plan_step(input logic opc, input logic [31:0] gx, input logic [31:0] gy);
        longint    vx, vy, w, c, dgx, dgy, dgw;
        ctrl_out_t r;
        vx = 3277;
        vy = 3277;
        w = 3277;
        if (opc == gdpc_pkg::OPC_SET)
        begin
            tgt_x = longint'(signed'(gx));
            tgt_y = longint'(signed'(gy));
            armed = 1;
            return;
        end
        if (!armed) return;
        for (int it = 0; it < 100; it++)
        begin
            c = plan_cost(vx, vy, w);
            dgx = (plan_cost(vx + 655, vy, w) - c) * 100;
            dgy = (plan_cost(vx, vy + 655, w) - c) * 100;
            dgw = (plan_cost(vx, vy, w + 655) - c) * 100;
            vx = clamp_to(vx - dgx, 65536);
            vy = clamp_to(vy - dgy, 65536);
            w = clamp_to(w - dgw, 51472);
        end
        pose_x = integrate(pose_x, vx);
        pose_y = integrate(pose_y, vy);
        heading = integrate(heading, w);
        r.reached = dist_from(pose_x, pose_y) < thresh;
        if (r.reached) armed = 0;
        r.vx = vx[17:0];
        r.vy = vy[17:0];
        r.w = w[16:0];
        r.px = pose_x[31:0];
        r.py = pose_y[31:0];
        r.hd = heading[31:0];
        ctrl_q = {ctrl_q, r};
    endtask

    function automatic int pick_gap();
        int k;
        if (no_idle) return 0;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // scoreboard, predictor update and timeout, all on the rising edge
    always @(posedge clk)
    begin
        ctrl_out_t e;
        logic [gdpc_pkg::OUT_W-1:0] d;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        took <= s_axis_tvalid && s_axis_tready;
        out_took <= m_axis_tvalid && m_axis_tready;
        if (rst_n && cfg_we)
        begin
            if (cfg_addr == gdpc_pkg::REG_STEP_TIME) dt = cfg_wdata[16:0];
            else if (cfg_addr == gdpc_pkg::REG_CTRL_WEIGHT) cweight = cfg_wdata[19:0];
            else if (cfg_addr == gdpc_pkg::REG_REACH_THR) thresh = cfg_wdata[19:0];
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            d = m_axis_tdata;
            if (ctrl_q.size() == 0)
            begin
                $display("%0t unexpected result beat: expected none, actual %h", $realtime, d);
                errors <= errors + 1;
            end
            else
            begin
                e = ctrl_q.pop_front();
                if (d[17:0] !== e.vx || d[35:18] !== e.vy || d[52:36] !== e.w ||
                    d[84:53] !== e.px || d[116:85] !== e.py || d[148:117] !== e.hd ||
                    d[149] !== e.reached)
                begin
                    $display("%0t mismatch: expected vx %h vy %h w %h x %h y %h hd %h r %b",
                             $realtime, e.vx, e.vy, e.w, e.px, e.py, e.hd, e.reached);
                    $display("%0t           actual vx %h vy %h w %h x %h y %h hd %h r %b",
                             $realtime, d[17:0], d[35:18], d[52:36], d[84:53], d[116:85],
                             d[148:117], d[149]);
                    errors <= errors + 1;
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
            plan_step(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32]);
    end

    // input driver
    always @(negedge clk)
    begin
        pose_cmd_t c;
        int g;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || took)
        begin
            g = in_gap;
            if (s_axis_tvalid && took)
                g = pick_gap();
            if (g > 0)
            begin
                in_gap <= g - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_q.size() > 0)
            begin
                c = cmd_q.pop_front();
                in_gap <= 0;
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= c.opc;
                s_axis_tdata <= {c.gy, c.gx};
            end
            else
            begin
                in_gap <= 0;
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure: a gap picked after each beat holds off the next one
    always @(negedge clk)
    begin
        int g;
        g = out_took ? pick_gap() : out_gap;
        if (g > 0)
        begin
            m_axis_tready <= 1'b0;
            if (m_axis_tvalid)
                out_gap <= g - 1;
            else
                out_gap <= g;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            out_gap <= 0;
        end
    end

    task automatic push_cmd(input logic opc, input logic [31:0] gx, input logic [31:0] gy);
        pose_cmd_t c;
        c.opc = opc;
        c.gx = gx;
        c.gy = gy;
        cmd_q = {cmd_q, c};
    endtask

    task automatic write_reg(input logic [gdpc_pkg::CFG_AW-1:0] a,
                             input logic [gdpc_pkg::CFG_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || s_axis_tvalid || ctrl_q.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // well-formed runs near the current pose, with some noise
    task automatic random_phase(input int n);
        int k, runs;
        logic [31:0] gx, gy;
        k = 0;
        while (k < n)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                gx = 32'(pose_x + $signed($urandom_range(0, 393216)) - 196608);
                gy = 32'(pose_y + $signed($urandom_range(0, 393216)) - 196608);
                push_cmd(gdpc_pkg::OPC_SET, gx, gy);
                runs = $urandom_range(1, 4);
                for (int i = 0; i < runs; i++)
                    push_cmd(gdpc_pkg::OPC_TICK, $urandom, $urandom);
                k = k + runs + 1;
            end
            else
            begin
                push_cmd(logic'($urandom_range(0, 1)), $urandom, $urandom);
                k = k + 1;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        took = 1'b0;
        out_took = 1'b0;
        in_gap = 0;
        out_gap = 0;
        no_idle = 0;
        errors = 0;
        cycles = 0;
        pose_x = 0; pose_y = 0; heading = 0; tgt_x = 0; tgt_y = 0; armed = 0;
        dt = gdpc_pkg::STEP_RST;
        cweight = gdpc_pkg::CWGT_RST;
        thresh = gdpc_pkg::THR_RST;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: tick with no target, coincident target, far targets, re-arm
        push_cmd(gdpc_pkg::OPC_TICK, 32'h0, 32'h0);
        push_cmd(gdpc_pkg::OPC_SET, 32'h0, 32'h0);
        push_cmd(gdpc_pkg::OPC_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(gdpc_pkg::OPC_TICK, 32'h0, 32'h0);
        push_cmd(gdpc_pkg::OPC_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        push_cmd(gdpc_pkg::OPC_TICK, 32'h0, 32'h0);
        push_cmd(gdpc_pkg::OPC_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        push_cmd(gdpc_pkg::OPC_SET, 32'hFFFE_0000, 32'h0002_0000);
        push_cmd(gdpc_pkg::OPC_TICK, 32'h0, 32'h0);
        push_cmd(gdpc_pkg::OPC_TICK, 32'h0, 32'h0);
        push_cmd(gdpc_pkg::OPC_SET, 32'h0000_1000, 32'hFFFF_F000);
        push_cmd(gdpc_pkg::OPC_TICK, 32'h0, 32'h0);
        push_cmd(gdpc_pkg::OPC_TICK, 32'h0, 32'h0);
        drain();

        // extremes one way, then the other, with high bits of step_time set
        write_reg(gdpc_pkg::REG_STEP_TIME, 20'h1_0000);
        write_reg(gdpc_pkg::REG_CTRL_WEIGHT, 20'd0);
        write_reg(gdpc_pkg::REG_REACH_THR, 20'd655360);
        no_idle = 1;
        random_phase(22);
        drain();

        write_reg(gdpc_pkg::REG_STEP_TIME, 20'hE_0000);
        write_reg(gdpc_pkg::REG_CTRL_WEIGHT, 20'd655360);
        write_reg(gdpc_pkg::REG_REACH_THR, 20'd0);
        no_idle = 0;
        random_phase(22);
        drain();

        for (int p = 0; p < 2; p++)
        begin
            write_reg(gdpc_pkg::REG_STEP_TIME,
                      gdpc_pkg::CFG_W'($urandom_range(0, 65536)));
            write_reg(gdpc_pkg::REG_CTRL_WEIGHT,
                      gdpc_pkg::CFG_W'($urandom_range(0, 655360)));
            write_reg(gdpc_pkg::REG_REACH_THR,
                      gdpc_pkg::CFG_W'($urandom_range(0, 655360)));
            random_phase(22);
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
rtl/core/gdpc_pkg.sv
rtl/core/gdpc_ctrl.sv
rtl/core/gdpc_dp.sv
rtl/core/gradient_descent_pose_controller.sv
verif/gradient_descent_pose_controller_tb.sv
